FILE: design/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and codes of the subtask dispatcher
// Field widths, action and result codes, and the command and status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam int ACTION_W         = 2;
  localparam int IDX_W            = 6;
  localparam int ROW_W            = 64;
  localparam int CNT_W            = 7;
  localparam int KIND_W           = 2;
  localparam int MAX_SUBTASKS_DEF = 64;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [KIND_W-1:0]   kind_t;

  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_START = 2'd1;
  localparam action_t ACT_END   = 2'd2;

  localparam kind_t KIND_NONE       = 2'd0;
  localparam kind_t KIND_DISPATCH   = 2'd1;
  localparam kind_t KIND_DONE_OK    = 2'd2;
  localparam kind_t KIND_DONE_FAULT = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic rd_en;    // read one adjacency row
    idx_t rd_addr;
    logic acc_en;   // fold returned row into blocked vector
    logic eval;     // form ready vector
    logic emit;     // load next result into output register
  } dsd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_sweep;   // offered beat is a start or an in-range end
    idx_t last_row;   // active count minus one
    logic slot_free;  // output register can take a result
    logic emit_last;  // next result closes the item
  } dsd_stat_t;

endpackage

FILE: design/dag_subtask_dispatcher.sv
// ----------------------------------------------------------------------------
// dag_subtask_dispatcher: dependency scoreboard and dispatcher for one
// command of up to MAX_SUBTASKS subtasks.
// Load: no result. Start or in-range end: n active rows are read
// from the row RAM one per cycle, then the first result is registered;
// later results follow one per cycle while out_ready does not stall them.
// The next input beat is taken once the last result of an item is loaded.
// Reset (rst_n low, synchronous) clears masks, fault flag and count (to 1);
// adjacency rows hold no value until loaded.
// ----------------------------------------------------------------------------
module dag_subtask_dispatcher #(
  parameter int MAX_SUBTASKS = dsd_pkg::MAX_SUBTASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsd_pkg::CNT_W-1:0]     cfg_subtask_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsd_pkg::ACTION_W-1:0]  in_action,
  input  logic [dsd_pkg::IDX_W-1:0]     in_subtask_index,
  input  logic [dsd_pkg::ROW_W-1:0]     in_row_bits,
  input  logic                          in_subtask_failed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsd_pkg::KIND_W-1:0]    out_result_kind,
  output logic [dsd_pkg::IDX_W-1:0]     out_dispatch_index,
  output logic                          out_last_result
);

  dsd_pkg::dsd_cmd_t  cmd;
  dsd_pkg::dsd_stat_t stat;

  assign cfg_ready = 1'b1;

  dsd_ctrl #(
    .MAX_SUBTASKS (MAX_SUBTASKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  dsd_dp #(
    .MAX_SUBTASKS (MAX_SUBTASKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_valid          (cfg_valid),
    .cfg_subtask_count  (cfg_subtask_count),
    .in_action          (in_action),
    .in_subtask_index   (in_subtask_index),
    .in_row_bits        (in_row_bits),
    .in_subtask_failed  (in_subtask_failed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_dispatch_index (out_dispatch_index),
    .out_last_result    (out_last_result)
  );

endmodule

FILE: design/dsd_ram.sv
// ----------------------------------------------------------------------------
// dsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dsd_ctrl.sv
// ----------------------------------------------------------------------------
// dsd_ctrl: sequencer of the subtask dispatcher
// Takes one input beat; on start or in-range end, sweeps the active adjacency
// rows, evaluates readiness and drains results one per cycle while slot_free.
// ----------------------------------------------------------------------------
module dsd_ctrl #(
  parameter int MAX_SUBTASKS = dsd_pkg::MAX_SUBTASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dsd_pkg::dsd_stat_t stat_i,
  output dsd_pkg::dsd_cmd_t  cmd_o
);

  localparam int AW = $clog2(MAX_SUBTASKS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          rd_pend_r;
  logic          sweep_end;

  assign in_ready  = (state_r == ST_IDLE);
  assign sweep_end = (dsd_pkg::idx_t'(cnt_r) == stat_i.last_row);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_o         = '0;
    cmd_o.rd_addr = dsd_pkg::idx_t'(cnt_r);
    cmd_o.acc_en  = rd_pend_r;
    case (state_r)
      ST_IDLE: begin
        cmd_o.accept = in_valid;
        cnt_nxt      = '0;
        if (in_valid && stat_i.go_sweep) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.rd_en = 1'b1;
        cnt_nxt     = cnt_r + AW'(1);
        if (sweep_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= cmd_o.rd_en;
    end
    cnt_r <= cnt_nxt;
  end

  // Sweep never runs past the last active row
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (dsd_pkg::idx_t'(cnt_r) <= stat_i.last_row))
    else $error("row sweep overran active count");

endmodule

FILE: design/dsd_dp.sv
// ----------------------------------------------------------------------------
// dsd_dp: datapath of the subtask dispatcher
// Adjacency row store, pending and outstanding masks, blocked-column
// accumulator, ready vector with priority pick, and the output register.
// ----------------------------------------------------------------------------
module dsd_dp #(
  parameter int MAX_SUBTASKS = dsd_pkg::MAX_SUBTASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsd_pkg::dsd_cmd_t             cmd_i,
  output dsd_pkg::dsd_stat_t            stat_o,
  input  logic                          cfg_valid,
  input  logic [dsd_pkg::CNT_W-1:0]     cfg_subtask_count,
  input  logic [dsd_pkg::ACTION_W-1:0]  in_action,
  input  logic [dsd_pkg::IDX_W-1:0]     in_subtask_index,
  input  logic [dsd_pkg::ROW_W-1:0]     in_row_bits,
  input  logic                          in_subtask_failed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsd_pkg::KIND_W-1:0]    out_result_kind,
  output logic [dsd_pkg::IDX_W-1:0]     out_dispatch_index,
  output logic                          out_last_result
);

  localparam int M  = MAX_SUBTASKS;
  localparam int AW = $clog2(MAX_SUBTASKS);
  localparam dsd_pkg::cnt_t MAX_N = dsd_pkg::cnt_t'(MAX_SUBTASKS);

  typedef logic [M-1:0] vec_t;

  dsd_pkg::cnt_t  count_r, count_nxt;
  vec_t           pending_r, pending_nxt;
  vec_t           outstanding_r, outstanding_nxt;
  logic           fault_r, fault_nxt;
  vec_t           blocked_r, blocked_nxt;
  logic           is_end_r, is_end_nxt;
  logic           retired_r, retired_nxt;
  vec_t           ready_r, ready_nxt;
  logic           done_r, done_nxt;
  logic           out_valid_r, out_valid_nxt;
  dsd_pkg::kind_t out_kind_r, out_kind_nxt;
  dsd_pkg::idx_t  out_idx_r, out_idx_nxt;
  logic           out_last_r, out_last_nxt;

  dsd_pkg::cnt_t  n_sat;
  vec_t           low_mask;
  vec_t           ready_all, ready_one, ready_iso, ready_rest;
  logic [AW-1:0]  lo_idx;
  logic [AW-1:0]  idx_a;
  logic           in_range, load_ok, slot_free, emit_last;
  logic           ram_we;
  vec_t           ram_wdata, ram_rdata;

  // Active count, held to 1..MAX_SUBTASKS
  always_comb begin
    if (count_r == '0) begin
      n_sat = dsd_pkg::cnt_t'(1);
    end else if (count_r > MAX_N) begin
      n_sat = MAX_N;
    end else begin
      n_sat = count_r;
    end
  end

  always_comb begin
    for (int j = 0; j < M; j++) begin
      low_mask[j] = (dsd_pkg::cnt_t'(j) < n_sat);
    end
  end

  assign idx_a    = in_subtask_index[AW-1:0];
  assign in_range = (dsd_pkg::cnt_t'(in_subtask_index) < n_sat);
  assign load_ok  = (dsd_pkg::cnt_t'(in_subtask_index) < MAX_N);

  assign ready_all = pending_r & ~blocked_r & low_mask;
  assign ready_one = ready_all & (~ready_all + M'(1));
  assign ready_iso = ready_r & (~ready_r + M'(1));
  assign ready_rest = ready_r & ~ready_iso;

  // Lowest set bit of the ready vector
  always_comb begin
    lo_idx = '0;
    for (int j = M - 1; j >= 0; j--) begin
      if (ready_r[j]) begin
        lo_idx = AW'(j);
      end
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign emit_last = (ready_r != '0) ? ((ready_rest == '0) && !done_r) : 1'b1;

  assign stat_o.go_sweep  = (in_action == dsd_pkg::ACT_START) ||
                            ((in_action == dsd_pkg::ACT_END) && in_range);
  assign stat_o.last_row  = dsd_pkg::idx_t'(n_sat - dsd_pkg::cnt_t'(1));
  assign stat_o.slot_free = slot_free;
  assign stat_o.emit_last = emit_last;

  always_comb begin
    count_nxt       = count_r;
    pending_nxt     = pending_r;
    outstanding_nxt = outstanding_r;
    fault_nxt       = fault_r;
    blocked_nxt     = blocked_r;
    is_end_nxt      = is_end_r;
    retired_nxt     = retired_r;
    ready_nxt       = ready_r;
    done_nxt        = done_r;
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_idx_nxt     = out_idx_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_wdata       = in_row_bits[M-1:0];

    if (cfg_valid) begin
      count_nxt = cfg_subtask_count;
    end

    if (cmd_i.accept) begin
      case (in_action)
        dsd_pkg::ACT_LOAD: begin
          ram_we = load_ok;
        end
        dsd_pkg::ACT_START: begin
          pending_nxt     = low_mask;
          outstanding_nxt = low_mask;
          fault_nxt       = 1'b0;
          blocked_nxt     = '0;
          is_end_nxt      = 1'b0;
          retired_nxt     = 1'b0;
        end
        dsd_pkg::ACT_END: begin
          if (in_range) begin
            blocked_nxt = '0;
            is_end_nxt  = 1'b1;
            retired_nxt = 1'b0;
            // Retire: drop the outstanding bit, zero the row and fold in the failure flag
            if (outstanding_r[idx_a]) begin
              retired_nxt            = 1'b1;
              outstanding_nxt[idx_a] = 1'b0;
              ram_we                 = 1'b1;
              ram_wdata              = '0;
              fault_nxt              = fault_r | in_subtask_failed;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.acc_en) begin
      blocked_nxt = blocked_r | ram_rdata;
    end

    if (cmd_i.eval) begin
      ready_nxt   = is_end_r ? ready_one : ready_all;
      pending_nxt = pending_r & ~(is_end_r ? ready_one : ready_all);
      done_nxt    = retired_r && (outstanding_r == '0);
    end

    if (cmd_i.emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = emit_last;
      out_idx_nxt   = '0;
      if (ready_r != '0) begin
        out_kind_nxt = dsd_pkg::KIND_DISPATCH;
        out_idx_nxt  = dsd_pkg::idx_t'(lo_idx);
        ready_nxt    = ready_rest;
      end else if (done_r) begin
        out_kind_nxt = fault_r ? dsd_pkg::KIND_DONE_FAULT : dsd_pkg::KIND_DONE_OK;
        done_nxt     = 1'b0;
      end else begin
        out_kind_nxt = dsd_pkg::KIND_NONE;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= dsd_pkg::cnt_t'(1);
      pending_r     <= '0;
      outstanding_r <= '0;
      fault_r       <= 1'b0;
      ready_r       <= '0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      pending_r     <= pending_nxt;
      outstanding_r <= outstanding_nxt;
      fault_r       <= fault_nxt;
      ready_r       <= ready_nxt;
      done_r        <= done_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    blocked_r  <= blocked_nxt;
    is_end_r   <= is_end_nxt;
    retired_r  <= retired_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  dsd_ram #(
    .WIDTH (M),
    .DEPTH (M)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_a),
    .wdata (ram_wdata),
    .re    (cmd_i.rd_en),
    .raddr (cmd_i.rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_dispatch_index = out_idx_r;
  assign out_last_result    = out_last_r;

  // A subtask queued for dispatch is no longer pending
  assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r & pending_r) == '0)
    else $error("ready subtask still marked pending");

  // Completion is only queued once every subtask has ended
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (outstanding_r == '0))
    else $error("completion queued with subtasks outstanding");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> slot_free)
    else $error("result emitted into occupied output register");

endmodule
